// File: sv/vdq_pkg.sv
// Shared types and constants for the VRAM DMA descriptor queue.
package vdq_pkg;

  // Widths of the item fields.
  localparam int SRC_W   = 24;
  localparam int DEST_W  = 16;
  localparam int LEN_W   = 16;
  localparam int MODE_W  = 8;
  localparam int SPLIT_W = 2;
  localparam int KIND_W  = 2;
  localparam int MAXE_W  = 5;
  localparam int SUM_BUDGET_W = 18;
  localparam int CHUNK_W = 3;
  localparam int DESC_W  = MODE_W + DEST_W + SRC_W + LEN_W;

  // Stream and configuration bus widths.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Command codes carried in the input tuser.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DESC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // Mode byte of the fill descriptor: increment after the high byte.
  localparam logic [MODE_W-1:0] FILL_VRAM_MODE = 8'h80;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_NORMAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_LONG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_VBLANK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD2     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD3     = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [MAXE_W-1:0] RST_MAX_ENTRIES   = 5'd16;
  localparam logic [LEN_W-1:0]  RST_BUDGET_NORMAL = 16'd4096;
  localparam logic [LEN_W-1:0]  RST_BUDGET_LONG   = 16'd8192;

  // Configuration register set.
  typedef struct packed {
    logic [MAXE_W-1:0]      max_entries;
    logic [LEN_W-1:0]       budget_normal;
    logic [LEN_W-1:0]       budget_long;
    logic                   long_vblank;
    logic [3:0][LEN_W-1:0]  overhead;
  } cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRITE,
    ST_STATUS,
    ST_FL_NEXT,
    ST_FL_OUT,
    ST_FILL,
    ST_EMPTY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic write_chunk;
    logic commit_budget;
    logic load_status;
    logic rd_issue;
    logic load_desc;
    logic load_fill;
    logic load_empty;
    logic clear;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic admit;
    logic chunk_last;
    logic more;
    logic fill_en;
    logic queue_empty;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/vdq_cfg.sv
// Configuration register file of the descriptor queue.
module vdq_cfg
  import vdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register write on each completed transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_entries   <= RST_MAX_ENTRIES;
      cfg.budget_normal <= RST_BUDGET_NORMAL;
      cfg.budget_long   <= RST_BUDGET_LONG;
      cfg.long_vblank   <= 1'b0;
      cfg.overhead      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_ENTRIES:   cfg.max_entries   <= cfg_data[MAXE_W-1:0];
        REG_BUDGET_NORMAL: cfg.budget_normal <= cfg_data;
        REG_BUDGET_LONG:   cfg.budget_long   <= cfg_data;
        REG_LONG_VBLANK:   cfg.long_vblank   <= cfg_data[0];
        REG_OVERHEAD0:     cfg.overhead[0]   <= cfg_data;
        REG_OVERHEAD1:     cfg.overhead[1]   <= cfg_data;
        REG_OVERHEAD2:     cfg.overhead[2]   <= cfg_data;
        REG_OVERHEAD3:     cfg.overhead[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/vdq_ctrl.sv
// Controller state machine of the descriptor queue.
module vdq_ctrl
  import vdq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_command,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_command == CMD_FLUSH) ? ST_FL_NEXT : ST_CHECK;
        end
      end
      ST_CHECK: state_next = ST_WRITE;
      ST_WRITE: begin
        if (!status.admit || status.chunk_last) begin
          state_next = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FL_NEXT: begin
        if (status.more) begin
          state_next = ST_FL_OUT;
        end else if (status.fill_en) begin
          state_next = ST_FILL;
        end else if (status.queue_empty) begin
          state_next = ST_EMPTY;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FL_OUT: begin
        if (status.out_free) begin
          state_next = ST_FL_NEXT;
        end
      end
      ST_FILL, ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CHECK: cmd.check = 1'b1;
      ST_WRITE: begin
        cmd.write_chunk   = status.admit;
        cmd.commit_budget = status.admit && status.chunk_last;
      end
      ST_STATUS: cmd.load_status = status.out_free;
      ST_FL_NEXT: begin
        cmd.rd_issue = status.more;
        cmd.clear    = !status.more && !status.fill_en && !status.queue_empty;
      end
      ST_FL_OUT: cmd.load_desc = status.out_free;
      ST_FILL: begin
        cmd.load_fill = status.out_free;
        cmd.clear     = status.out_free;
      end
      ST_EMPTY: begin
        cmd.load_empty = status.out_free;
        cmd.clear      = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/vdq_dp.sv
// Datapath of the descriptor queue: item registers, admission check,
// descriptor memory, counters and the output register.
module vdq_dp
  import vdq_pkg::*;
#(
  parameter int QUEUE_DEPTH       = 16,
  parameter int SPLIT_SRC_STRIDE  = 512,
  parameter int SPLIT_DEST_STRIDE = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  cfg_t                   cfg,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser,
  output logic                   m_tlast
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W = ((CNT_W > MAXE_W) ? CNT_W : MAXE_W) + 4;

  // Item registers; source and destination also step per chunk.
  logic [SRC_W-1:0]   src_cur;
  logic [DEST_W-1:0]  dst_cur;
  logic [LEN_W-1:0]   item_len;
  logic [MODE_W-1:0]  item_mode;
  logic [SPLIT_W-1:0] item_split;
  logic               item_fill;
  logic [CHUNK_W-1:0] chunk_idx;
  logic [CHUNK_W-1:0] chunk_max;

  // Queue state.
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   rd_idx;
  logic [LEN_W-1:0]   budget_used;
  logic [LEN_W-1:0]   budget_total;
  logic               admit;

  logic [DESC_W-1:0]  mem [QUEUE_DEPTH];
  logic [DESC_W-1:0]  rd_data;

  // Admission arithmetic.
  logic [SUM_W-1:0]        count_sum;
  logic [SUM_W-1:0]        limit;
  logic [SUM_W-1:0]        max_ext;
  logic [SUM_W-1:0]        depth_ext;
  logic [SUM_BUDGET_W-1:0] total;
  logic [LEN_W-1:0]        budget_sel;

  // Output register.
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic                out_accepted;
  logic [MODE_W-1:0]   out_mode;
  logic [DEST_W-1:0]   out_addr;
  logic [SRC_W-1:0]    out_src;
  logic [LEN_W-1:0]    out_len;
  logic                out_fixed;
  logic                out_last;
  logic                out_free;
  logic                load_any;

  assign chunk_max  = CHUNK_W'((4'd1 << item_split) - 4'd1);
  assign max_ext    = SUM_W'(cfg.max_entries);
  assign depth_ext  = SUM_W'(QUEUE_DEPTH);
  assign limit      = (max_ext < depth_ext) ? max_ext : depth_ext;
  assign count_sum  = SUM_W'(entry_count) + SUM_W'(4'd1 << item_split);
  assign budget_sel = cfg.long_vblank ? cfg.budget_long : cfg.budget_normal;
  assign total      = SUM_BUDGET_W'(budget_used) + SUM_BUDGET_W'(item_len)
                    + SUM_BUDGET_W'(cfg.overhead[item_split]);

  // Item capture and chunk stepping.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src_cur    <= s_tdata[23:0];
      dst_cur    <= s_tdata[39:24];
      item_len   <= s_tdata[55:40];
      item_mode  <= s_tdata[63:56];
      item_split <= s_tdata[65:64];
      item_fill  <= s_tdata[66];
    end else if (cmd.write_chunk) begin
      src_cur <= src_cur + SRC_W'(SPLIT_SRC_STRIDE);
      dst_cur <= dst_cur + DEST_W'(SPLIT_DEST_STRIDE);
    end
  end

  // Admission decision and the budget total it implies.
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      admit        <= (count_sum <= limit) && (total <= SUM_BUDGET_W'(budget_sel));
      budget_total <= total[LEN_W-1:0];
    end
  end

  // Counters and the budget.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      rd_idx      <= '0;
      budget_used <= '0;
      chunk_idx   <= '0;
    end else begin
      if (cmd.capture) begin
        chunk_idx <= '0;
      end else if (cmd.write_chunk) begin
        chunk_idx <= chunk_idx + CHUNK_W'(1);
      end
      if (cmd.clear) begin
        entry_count <= '0;
        rd_idx      <= '0;
        budget_used <= '0;
      end else begin
        if (cmd.write_chunk) begin
          entry_count <= entry_count + CNT_W'(1);
        end
        if (cmd.load_desc) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (cmd.commit_budget) begin
          budget_used <= budget_total;
        end
      end
    end
  end

  // Descriptor memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_chunk) begin
      mem[entry_count[IDX_W-1:0]] <= {item_mode, dst_cur, src_cur, item_len >> item_split};
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Output register; a new result may load as the old one is taken.
  assign out_free = !out_valid || m_tready;
  assign load_any = cmd.load_status || cmd.load_desc || cmd.load_fill || cmd.load_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_any) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_any) begin
      out_kind     <= KIND_STATUS;
      out_accepted <= 1'b0;
      out_mode     <= '0;
      out_addr     <= '0;
      out_src      <= '0;
      out_len      <= '0;
      out_fixed    <= 1'b0;
      out_last     <= 1'b1;
      if (cmd.load_status) begin
        out_accepted <= admit;
      end else if (cmd.load_desc) begin
        out_kind <= KIND_DESC;
        out_mode <= rd_data[63:56];
        out_addr <= rd_data[55:40];
        out_src  <= rd_data[39:16];
        out_len  <= rd_data[15:0];
        out_last <= (CNT_W'(rd_idx + CNT_W'(1)) == entry_count) && !item_fill;
      end else if (cmd.load_fill) begin
        out_kind  <= KIND_DESC;
        out_mode  <= FILL_VRAM_MODE;
        out_addr  <= dst_cur;
        out_src   <= src_cur;
        out_len   <= item_len;
        out_fixed <= 1'b1;
      end else begin
        out_kind <= KIND_EMPTY;
      end
    end
  end

  // Status to the controller.
  assign status.admit       = admit;
  assign status.chunk_last  = (chunk_idx == chunk_max);
  assign status.more        = (rd_idx < entry_count);
  assign status.fill_en     = item_fill;
  assign status.queue_empty = (entry_count == '0);
  assign status.out_free    = out_free;

  // Result stream.
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_len, out_src, out_addr, out_mode, out_accepted};
  assign m_tuser  = {out_fixed, out_kind};
  assign m_tlast  = out_last;

endmodule

// File: sv/vram_dma_descriptor_queue_core.sv
// Top level of the VRAM DMA descriptor queue with a per-frame byte budget.
//
//  Group  | Role          | Handshake            | Content
//  -------+---------------+----------------------+------------------------------------
//  s_*    | item in       | s_tvalid / s_tready  | add or flush request
//  m_*    | result out    | m_tvalid / m_tready  | add status, descriptor or empty, tlast ends
//  cfg_*  | register write| cfg_valid / cfg_ready| index and 16-bit data
//
// One item is worked on at a time; the result register lets the next item be taken
// while the last result waits. An add writes its stored chunks (1, 2, 4 or 8; none
// when rejected) and then loads its status. A flush sends the stored descriptors
// in order, each memory read registered before the result register, then a fill
// descriptor if enabled or, on an empty queue, an empty result. Reset (rst,
// synchronous) empties the queue and restores the register defaults; m_tready stalls.
module vram_dma_descriptor_queue_core
  import vdq_pkg::*;
#(
  parameter int QUEUE_DEPTH       = 16,
  parameter int SPLIT_SRC_STRIDE  = 512,
  parameter int SPLIT_DEST_STRIDE = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // source_address[23:0], vram_dest[39:24], byte_length[55:40],
  // vram_mode[63:56], split_log2[65:64], fill_enable[66], zero[71:67]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // command[0]
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // accepted[0], out_vram_mode[8:1], out_vram_addr[24:9], out_source[48:25],
  // out_length[64:49], zero[71:65]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // result_kind[1:0], fixed_source[2]
  output logic [OUT_TUSER_W-1:0] m_tuser,
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration registers.
  vdq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencing of adds and flushes.
  vdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tuser),
    .in_ready   (s_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Queue storage and arithmetic.
  vdq_dp #(
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .SPLIT_SRC_STRIDE  (SPLIT_SRC_STRIDE),
    .SPLIT_DEST_STRIDE (SPLIT_DEST_STRIDE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the VRAM DMA descriptor queue core.
module tb;
  import vdq_pkg::*;

  localparam int QUEUE_DEPTH       = 16;
  localparam int SPLIT_SRC_STRIDE  = 512;
  localparam int SPLIT_DEST_STRIDE = 256;
  localparam int CYCLE_LIMIT       = 600000;
  localparam int DRAIN_CYCLES      = 40;

  // One result of the queue as it appears on the output stream.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              accepted;
    logic [MODE_W-1:0] mode;
    logic [DEST_W-1:0] addr;
    logic [SRC_W-1:0]  source;
    logic [LEN_W-1:0]  length;
    logic              fixed;
    logic              last;
  } result_t;

  // One stored chunk descriptor.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DEST_W-1:0] dest;
    logic [SRC_W-1:0]  src;
    logic [LEN_W-1:0]  len;
  } desc_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the queue and its registers, and the results still due.
  cfg_t        shadow_cfg;
  desc_t       stored [QUEUE_DEPTH];
  int unsigned queued_count;
  int unsigned budget_spent;
  result_t     due_results [$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  send_idle   = 1'b1;
  bit  recv_idle   = 1'b1;
  int  recv_hold   = 0;
  result_t seen;
  result_t want;

  vram_dma_descriptor_queue_core #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .SPLIT_SRC_STRIDE (SPLIT_SRC_STRIDE),
    .SPLIT_DEST_STRIDE(SPLIT_DEST_STRIDE)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 30);
  endfunction

  // Receiver back-pressure on the result stream.
  always @(posedge clk) begin
    if (!recv_idle) begin
      m_tready <= 1'b1;
    end else if (recv_hold > 0) begin
      recv_hold--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      recv_hold = pick_gap(1'b1);
      m_tready <= 1'b0;
    end
  end

  // Works out the results of one accepted item and updates the shadow queue.
  function automatic void predict_response(input logic cmd, input logic [SRC_W-1:0] src,
      input logic [DEST_W-1:0] dst, input logic [LEN_W-1:0] len,
      input logic [MODE_W-1:0] mode, input logic [SPLIT_W-1:0] split, input logic fill);
    int unsigned chunks, cap, total, budget, n, i;
    logic [SRC_W-1:0]  chunk_src;
    logic [DEST_W-1:0] chunk_dst;
    result_t r;
    r = '0;
    r.last = 1'b1;
    if (cmd == CMD_ADD) begin
      chunks = 1 << split;
      cap    = (32'(shadow_cfg.max_entries) < QUEUE_DEPTH) ?
               32'(shadow_cfg.max_entries) : QUEUE_DEPTH;
      total  = budget_spent + 32'(len) + 32'(shadow_cfg.overhead[split]);
      budget = shadow_cfg.long_vblank ? 32'(shadow_cfg.budget_long) :
               32'(shadow_cfg.budget_normal);
      r.kind = KIND_STATUS;
      // Admission needs room for every chunk and the whole sum within the budget.
      if (queued_count + chunks <= cap && total <= budget) begin
        chunk_src = src;
        chunk_dst = dst;
        for (i = 0; i < chunks; i++) begin
          stored[queued_count] = '{mode, chunk_dst, chunk_src, len >> split};
          queued_count++;
          chunk_src = chunk_src + SRC_W'(SPLIT_SRC_STRIDE);
          chunk_dst = chunk_dst + DEST_W'(SPLIT_DEST_STRIDE);
        end
        budget_spent = total & 32'hFFFF;
        r.accepted = 1'b1;
      end
      due_results.push_back(r);
    end else begin
      // A flush drains in order, then a fill if set or, if empty, an empty result.
      n = queued_count;
      for (i = 0; i < n; i++) begin
        r        = '0;
        r.kind   = KIND_DESC;
        r.mode   = stored[i].mode;
        r.addr   = stored[i].dest;
        r.source = stored[i].src;
        r.length = stored[i].len;
        r.last   = (i + 1 == n) && !fill;
        due_results.push_back(r);
      end
      queued_count = 0;
      budget_spent = 0;
      if (fill) begin
        r        = '0;
        r.kind   = KIND_DESC;
        r.mode   = FILL_VRAM_MODE;
        r.addr   = dst;
        r.source = src;
        r.length = len;
        r.fixed  = 1'b1;
        r.last   = 1'b1;
        due_results.push_back(r);
      end else if (n == 0) begin
        r      = '0;
        r.kind = KIND_EMPTY;
        r.last = 1'b1;
        due_results.push_back(r);
      end
    end
  endfunction

  // Sends one item on the input stream; valid stays high for a following item.
  task automatic issue_request(input logic cmd, input logic [SRC_W-1:0] src,
      input logic [DEST_W-1:0] dst, input logic [LEN_W-1:0] len,
      input logic [MODE_W-1:0] mode, input logic [SPLIT_W-1:0] split, input logic fill);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, fill, split, mode, len, dst, src};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    predict_response(cmd, src, dst, len, mode, split, fill);
  endtask

  // An add carries a random fill flag, which the block must ignore.
  task automatic send_add(input logic [SRC_W-1:0] src, input logic [DEST_W-1:0] dst,
      input logic [LEN_W-1:0] len, input logic [MODE_W-1:0] mode,
      input logic [SPLIT_W-1:0] split);
    issue_request(CMD_ADD, src, dst, len, mode, split, 1'($urandom_range(0, 1)));
  endtask

  // A flush carries random mode and split fields, which the block must ignore.
  task automatic send_flush(input logic [SRC_W-1:0] src, input logic [DEST_W-1:0] dst,
      input logic [LEN_W-1:0] len, input logic fill);
    issue_request(CMD_FLUSH, src, dst, len, MODE_W'($urandom), SPLIT_W'($urandom), fill);
  endtask

  // Lowers valid and waits until every due result has been transferred.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write transfer; valid stays high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      REG_MAX_ENTRIES:   shadow_cfg.max_entries   = data[MAXE_W-1:0];
      REG_BUDGET_NORMAL: shadow_cfg.budget_normal = data;
      REG_BUDGET_LONG:   shadow_cfg.budget_long   = data;
      REG_LONG_VBLANK:   shadow_cfg.long_vblank   = data[0];
      REG_OVERHEAD0:     shadow_cfg.overhead[0]   = data;
      REG_OVERHEAD1:     shadow_cfg.overhead[1]   = data;
      REG_OVERHEAD2:     shadow_cfg.overhead[2]   = data;
      REG_OVERHEAD3:     shadow_cfg.overhead[3]   = data;
      default: ;
    endcase
  endtask

  // Writes the whole register set once the block has gone idle.
  task automatic apply_settings(input logic [15:0] maxe, input logic [15:0] normal,
      input logic [15:0] longb, input logic [15:0] lv, input logic [15:0] ov0,
      input logic [15:0] ov1, input logic [15:0] ov2, input logic [15:0] ov3);
    wait_idle();
    write_reg(REG_MAX_ENTRIES, maxe);
    write_reg(REG_BUDGET_NORMAL, normal);
    write_reg(REG_BUDGET_LONG, longb);
    write_reg(REG_LONG_VBLANK, lv);
    write_reg(REG_OVERHEAD0, ov0);
    write_reg(REG_OVERHEAD1, ov1);
    write_reg(REG_OVERHEAD2, ov2);
    write_reg(REG_OVERHEAD3, ov3);
    cfg_valid <= 1'b0;
  endtask

  // Reports one field that differs from its prediction.
  function automatic void compare_field(input string what, input logic [31:0] exp_v,
      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h, actual %0h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Result checker: outputs are stable at the falling edge, and a transfer
  // seen there completes at the next rising edge.
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.kind     = m_tuser[1:0];
      seen.fixed    = m_tuser[2];
      seen.accepted = m_tdata[0];
      seen.mode     = m_tdata[8:1];
      seen.addr     = m_tdata[24:9];
      seen.source   = m_tdata[48:25];
      seen.length   = m_tdata[64:49];
      seen.last     = m_tlast;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due, expected nothing, actual %0h", $time, seen);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        compare_field("result_kind", 32'(want.kind), 32'(seen.kind));
        compare_field("accepted", 32'(want.accepted), 32'(seen.accepted));
        compare_field("out_vram_mode", 32'(want.mode), 32'(seen.mode));
        compare_field("out_vram_addr", 32'(want.addr), 32'(seen.addr));
        compare_field("out_source", 32'(want.source), 32'(seen.source));
        compare_field("out_length", 32'(want.length), 32'(seen.length));
        compare_field("fixed_source", 32'(want.fixed), 32'(seen.fixed));
        compare_field("last", 32'(want.last), 32'(seen.last));
      end
    end
  end

  // Flushes of an empty queue, with and without a fill transfer, at reset settings.
  task automatic test_empty_flush();
    send_flush(24'h000000, 16'h0000, 16'h0000, 1'b0);
    send_flush(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_flush(24'h000000, 16'h0000, 16'h0000, 1'b1);
  endtask

  // Chunking, stride wrap at the top of both address spaces, and a full queue.
  task automatic test_split_chunks();
    apply_settings(16'd16, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_add(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3);
    send_add(24'h000000, 16'h0000, 16'h0000, 8'h00, 2'd0);
    send_add(24'h000001, 16'h0001, 16'h0001, 8'h01, 2'd0);
    send_flush(24'h000000, 16'h0000, 16'h0000, 1'b0);
    send_add(24'h123456, 16'h1234, 16'd7, 8'h5A, 2'd1);
    send_add(24'hABCDEF, 16'hFF80, 16'd13, 8'hA5, 2'd2);
    send_add(24'h000200, 16'h0100, 16'd100, 8'h3C, 2'd0);
    send_add(24'hFFFE00, 16'h0000, 16'd800, 8'hC3, 2'd3);
    send_add(24'h00F00F, 16'h7777, 16'd1, 8'h96, 2'd0);
    send_add(24'h000010, 16'h0010, 16'd1, 8'h69, 2'd0);
    send_flush(24'h0ABCDE, 16'h5555, 16'h0100, 1'b1);
  endtask

  // Budget edges: full-width sums beyond 16 bits and exact fits.
  task automatic test_budget_limits();
    apply_settings(16'd16, 16'd100, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_add(24'h010203, 16'h0405, 16'd0, 8'h11, 2'd0);
    send_add(24'h060708, 16'h090A, 16'd0, 8'h22, 2'd1);
    send_flush(24'h000000, 16'h0000, 16'h0000, 1'b0);
    apply_settings(16'd16, 16'd100, 16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd10);
    send_add(24'h300000, 16'h2000, 16'd90, 8'h44, 2'd3);
    send_add(24'h400000, 16'h3000, 16'd0, 8'h55, 2'd0);
    send_flush(24'h000000, 16'h0000, 16'h0000, 1'b0);
  endtask

  // Capacity: zero entries, values beyond the queue depth, and a single entry.
  task automatic test_capacity_limits();
    apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_add(24'h000100, 16'h0100, 16'd4, 8'h01, 2'd0);
    apply_settings(16'd31, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_add(24'h100000, 16'h1000, 16'd64, 8'h0F, 2'd3);
    send_add(24'h200000, 16'h2000, 16'd64, 8'hF0, 2'd3);
    send_add(24'h300000, 16'h3000, 16'd2, 8'h33, 2'd0);
    send_flush(24'h000000, 16'h0000, 16'h0000, 1'b0);
    apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_add(24'h500000, 16'h5000, 16'd6, 8'h5C, 2'd1);
    send_add(24'h600000, 16'h6000, 16'd6, 8'h6C, 2'd0);
    send_flush(24'h00FFFF, 16'h8000, 16'h0020, 1'b1);
  endtask

  // Random phases: mostly runs of adds closed by a flush, some random noise items.
  task automatic test_random_traffic();
    int phase, count, run_len, j;
    logic [15:0] maxe, normal, longb, ov [4];
    int unsigned bsel;
    logic [LEN_W-1:0] len;
    for (phase = 0; phase < 5; phase++) begin
      send_idle = (phase != 0) && (phase != 3);
      recv_idle = (phase != 0) && (phase != 2);
      if (phase == 0) begin
        maxe   = 16'd16;
        normal = 16'hFFFF;
        longb  = 16'hFFFF;
        for (j = 0; j < 4; j++) ov[j] = 16'($urandom_range(0, 32));
      end else begin
        j = $urandom_range(0, 9);
        maxe = (j == 0) ? 16'd0 : (j == 1) ? 16'd1 :
               (j == 2) ? 16'($urandom_range(17, 31)) : 16'($urandom_range(2, 16));
        maxe[15:MAXE_W] = (16 - MAXE_W)'($urandom);
        j = $urandom_range(0, 9);
        normal = (j < 2) ? 16'hFFFF : (j == 2) ? 16'd0 : 16'($urandom_range(256, 16000));
        j = $urandom_range(0, 9);
        longb = (j < 3) ? 16'hFFFF : (j == 3) ? 16'd0 : 16'($urandom_range(256, 16000));
        for (j = 0; j < 4; j++) begin
          case ($urandom_range(0, 9))
            0:       ov[j] = 16'($urandom);
            1, 2:    ov[j] = 16'($urandom_range(0, 2000));
            default: ov[j] = 16'($urandom_range(0, 64));
          endcase
        end
      end
      apply_settings(maxe, normal, longb, 16'($urandom), ov[0], ov[1], ov[2], ov[3]);
      bsel  = shadow_cfg.long_vblank ? 32'(shadow_cfg.budget_long) :
              32'(shadow_cfg.budget_normal);
      count = 0;
      while (count < 35) begin
        if ($urandom_range(0, 9) == 0) begin
          issue_request(1'($urandom), SRC_W'($urandom), DEST_W'($urandom), LEN_W'($urandom),
                        MODE_W'($urandom), SPLIT_W'($urandom), 1'($urandom));
          count++;
        end else begin
          run_len = $urandom_range(1, 8);
          for (j = 0; j < run_len; j++) begin
            case ($urandom_range(0, 9))
              0:       len = LEN_W'($urandom);
              1, 2:    len = LEN_W'($urandom_range(0, 600));
              default: len = LEN_W'($urandom_range(0, bsel / 6 + 1));
            endcase
            send_add(SRC_W'($urandom), DEST_W'($urandom), len, MODE_W'($urandom),
                     SPLIT_W'($urandom));
          end
          send_flush(SRC_W'($urandom), DEST_W'($urandom), LEN_W'($urandom), 1'($urandom));
          count += run_len + 1;
        end
      end
    end
  endtask

  initial begin
    shadow_cfg               = '0;
    shadow_cfg.max_entries   = RST_MAX_ENTRIES;
    shadow_cfg.budget_normal = RST_BUDGET_NORMAL;
    shadow_cfg.budget_long   = RST_BUDGET_LONG;
    queued_count             = 0;
    budget_spent             = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_flush();
    test_split_chunks();
    test_budget_limits();
    test_capacity_limits();
    test_random_traffic();
    // Drain the last results and watch for any stray transfer afterwards.
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
